/* hdl/gdb_pkg.sv */
// ----------------------------------------------------------------------------
// Graph traversal package
// Shared constants, command codes and structs of the traversal block.
// ----------------------------------------------------------------------------
package gdb_pkg;

  // Graph size and derived widths.
  localparam int NODE_MAX  = 64;
  localparam int VTX_W     = $clog2(NODE_MAX);
  localparam int CNT_W     = VTX_W + 1;
  localparam int FIELD_W   = 7;
  localparam int CFG_IDX_W = 2;

  // Find-first unit grouping.
  localparam int FFS_GRP    = 8;
  localparam int FFS_GRP_W  = $clog2(FFS_GRP);
  localparam int FFS_NGRP   = NODE_MAX / FFS_GRP;
  localparam int FFS_NGRP_W = VTX_W - FFS_GRP_W;

  // Command codes.
  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_DFS = 2'd1;
  localparam logic [1:0] KIND_BFS = 2'd2;
  localparam logic [1:0] KIND_CLR = 2'd3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_VERTEX = 2'd1;

  // Register reset values.
  localparam logic [FIELD_W-1:0] NODE_COUNT_RST = 7'd64;
  localparam logic [FIELD_W-1:0] START_RST      = 7'd1;

  // Order codes.
  localparam logic ORDER_DFS = 1'b0;
  localparam logic ORDER_BFS = 1'b1;

  // Request from the sequencer to the result stage.
  typedef struct packed {
    logic             prod;
    logic             done;
    logic [VTX_W-1:0] vtx;
    logic             okind;
  } emit_req_t;

  // Result of the find-first unit.
  typedef struct packed {
    logic             found;
    logic [VTX_W-1:0] idx;
  } ffs_res_t;

endpackage

/* hdl/graph_dfs_bfs_order.sv */
// An add edge reads row a, writes it, then reads and writes row b; a clear or a dropped
// edge leaves the block idle. A run visits the start vertex first, then finds
// one vertex at a time, pops the stack at dead ends (depth-first), or enqueues unvisited
// neighbors and dequeues the next (breadth-first). Each vertex is held back until
// the next one is found or the run ends, then shown for one cycle; the receiver cannot stall.
// Reset clears the graph through row valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Graph traversal top level
// Adjacency matrix storage with depth-first and breadth-first visiting order.
// ----------------------------------------------------------------------------
module graph_dfs_bfs_order (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      kind_i,
  input  logic [gdb_pkg::FIELD_W-1:0]     end_a_i,
  input  logic [gdb_pkg::FIELD_W-1:0]     end_b_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gdb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gdb_pkg::FIELD_W-1:0]     cfg_data_i,
  output logic                            result_valid_o,
  output logic [gdb_pkg::FIELD_W-1:0]     vertex_o,
  output logic                            order_kind_o,
  output logic                            last_o
);

  localparam int NM = gdb_pkg::NODE_MAX;
  localparam int VW = gdb_pkg::VTX_W;
  localparam int CW = gdb_pkg::CNT_W;
  localparam int FW = gdb_pkg::FIELD_W;

  // Sequencer state codes.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ADD_WA   = 3'd1;
  localparam logic [2:0] ST_ADD_RB   = 3'd2;
  localparam logic [2:0] ST_ADD_WB   = 3'd3;
  localparam logic [2:0] ST_DFS_FIND = 3'd4;
  localparam logic [2:0] ST_DFS_POP  = 3'd5;
  localparam logic [2:0] ST_BFS_DQ   = 3'd6;
  localparam logic [2:0] ST_BFS_EXP  = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [FW-1:0] node_count_q, start_vertex_q;
  logic [NM-1:0] visited_q, visited_d;
  logic [NM-1:0] row_vld_q, row_vld_d;
  logic          adj_rvld_q;
  logic [CW-1:0] depth_q, depth_d;
  logic [CW-1:0] head_q, head_d;
  logic [CW-1:0] tail_q, tail_d;
  logic          okind_q, okind_d;
  logic [VW-1:0] a_q, b_q;

  logic          accept;
  logic [FW-1:0] cnt;
  logic [NM-1:0] live_mask;
  logic [FW-1:0] a_m1, b_m1, s_m1;
  logic          edge_ok, start_ok;
  logic [CW-1:0] depth_m2;

  logic          adj_re, adj_we;
  logic [VW-1:0] adj_raddr, adj_waddr;
  logic [NM-1:0] adj_wdata, adj_rdata, adj_row;
  logic          lst_re, lst_we;
  logic [VW-1:0] lst_raddr, lst_waddr, lst_wdata, lst_rdata;
  logic [NM-1:0] cand;

  gdb_pkg::ffs_res_t  ffs;
  gdb_pkg::emit_req_t emit;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q   <= gdb_pkg::NODE_COUNT_RST;
      start_vertex_q <= gdb_pkg::START_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        gdb_pkg::REG_NODE_COUNT:   node_count_q   <= cfg_data_i;
        gdb_pkg::REG_START_VERTEX: start_vertex_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective vertex count and the mask of vertices in use.
  assign cnt = (node_count_q > FW'(NM)) ? FW'(NM) : node_count_q;

  always_comb begin
    for (int i = 0; i < NM; i++) begin
      live_mask[i] = (FW'(i) < cnt);
    end
  end

  // Zero-based indices and range checks.
  assign a_m1     = end_a_i - FW'(1);
  assign b_m1     = end_b_i - FW'(1);
  assign s_m1     = start_vertex_q - FW'(1);
  assign edge_ok  = (end_a_i != '0) && (end_a_i <= cnt) && (end_b_i != '0) && (end_b_i <= cnt);
  assign start_ok = (start_vertex_q != '0) && (start_vertex_q <= cnt);
  assign depth_m2 = depth_q - CW'(2);

  // Adjacency row storage; a row never written since the last clear reads as zero.
  gdb_ram #(
    .Width(NM),
    .Depth(NM)
  ) u_adj_ram (
    .clk_i  (clk_i),
    .we_i   (adj_we),
    .waddr_i(adj_waddr),
    .wdata_i(adj_wdata),
    .re_i   (adj_re),
    .raddr_i(adj_raddr),
    .rdata_o(adj_rdata)
  );

  assign adj_row = adj_rvld_q ? adj_rdata : '0;

  // Path stack in depth-first runs, pending queue in breadth-first runs.
  gdb_ram #(
    .Width(VW),
    .Depth(NM)
  ) u_list_ram (
    .clk_i  (clk_i),
    .we_i   (lst_we),
    .waddr_i(lst_waddr),
    .wdata_i(lst_wdata),
    .re_i   (lst_re),
    .raddr_i(lst_raddr),
    .rdata_o(lst_rdata)
  );

  // Shared search for the lowest unvisited neighbor of the current row.
  assign cand = adj_row & ~visited_q & live_mask;

  gdb_ffs u_ffs (
    .cand_i(cand),
    .res_o (ffs)
  );

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    visited_d  = visited_q;
    row_vld_d  = row_vld_q;
    depth_d    = depth_q;
    head_d     = head_q;
    tail_d     = tail_q;
    okind_d    = okind_q;
    adj_re     = 1'b0;
    adj_raddr  = '0;
    adj_we     = 1'b0;
    adj_waddr  = '0;
    adj_wdata  = adj_row;
    lst_re     = 1'b0;
    lst_raddr  = '0;
    lst_we     = 1'b0;
    lst_waddr  = '0;
    lst_wdata  = ffs.idx;
    emit       = '0;
    emit.okind = okind_q;
    emit.vtx   = ffs.idx;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_i)
            gdb_pkg::KIND_ADD: begin
              if (edge_ok) begin
                adj_re    = 1'b1;
                adj_raddr = a_m1[VW-1:0];
                state_d   = ST_ADD_WA;
              end
            end
            gdb_pkg::KIND_CLR: begin
              row_vld_d = '0;
              visited_d = '0;
            end
            gdb_pkg::KIND_DFS, gdb_pkg::KIND_BFS: begin
              visited_d = '0;
              if (start_ok) begin
                visited_d[s_m1[VW-1:0]] = 1'b1;
                okind_d    = (kind_i == gdb_pkg::KIND_BFS) ? gdb_pkg::ORDER_BFS
                                                           : gdb_pkg::ORDER_DFS;
                emit.prod  = 1'b1;
                emit.vtx   = s_m1[VW-1:0];
                emit.okind = okind_d;
                adj_re     = 1'b1;
                adj_raddr  = s_m1[VW-1:0];
                if (kind_i == gdb_pkg::KIND_DFS) begin
                  lst_we    = 1'b1;
                  lst_waddr = '0;
                  lst_wdata = s_m1[VW-1:0];
                  depth_d   = CW'(1);
                  state_d   = ST_DFS_FIND;
                end else begin
                  head_d  = '0;
                  tail_d  = '0;
                  state_d = ST_BFS_EXP;
                end
              end
            end
          endcase
        end
      end

      // Set the b bit in row a, then the a bit in row b.
      ST_ADD_WA: begin
        adj_we           = 1'b1;
        adj_waddr        = a_q;
        adj_wdata[b_q]   = 1'b1;
        row_vld_d[a_q]   = 1'b1;
        state_d          = ST_ADD_RB;
      end

      ST_ADD_RB: begin
        adj_re    = 1'b1;
        adj_raddr = b_q;
        state_d   = ST_ADD_WB;
      end

      ST_ADD_WB: begin
        adj_we         = 1'b1;
        adj_waddr      = b_q;
        adj_wdata[a_q] = 1'b1;
        row_vld_d[b_q] = 1'b1;
        state_d        = ST_IDLE;
      end

      // Descend into the lowest unvisited neighbor, or pop the stack.
      ST_DFS_FIND: begin
        if (ffs.found) begin
          visited_d[ffs.idx] = 1'b1;
          emit.prod = 1'b1;
          lst_we    = 1'b1;
          lst_waddr = depth_q[VW-1:0];
          depth_d   = depth_q + CW'(1);
          adj_re    = 1'b1;
          adj_raddr = ffs.idx;
        end else if (depth_q == CW'(1)) begin
          depth_d   = '0;
          emit.done = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          lst_re    = 1'b1;
          lst_raddr = depth_m2[VW-1:0];
          depth_d   = depth_q - CW'(1);
          state_d   = ST_DFS_POP;
        end
      end

      // The new stack top is back; fetch its row.
      ST_DFS_POP: begin
        adj_re    = 1'b1;
        adj_raddr = lst_rdata;
        state_d   = ST_DFS_FIND;
      end

      // A dequeued vertex is visited in order; fetch its row.
      ST_BFS_DQ: begin
        emit.prod = 1'b1;
        emit.vtx  = lst_rdata;
        adj_re    = 1'b1;
        adj_raddr = lst_rdata;
        state_d   = ST_BFS_EXP;
      end

      // Enqueue unvisited neighbors in ascending order, one per cycle.
      ST_BFS_EXP: begin
        if (ffs.found) begin
          visited_d[ffs.idx] = 1'b1;
          lst_we    = 1'b1;
          lst_waddr = tail_q[VW-1:0];
          tail_d    = tail_q + CW'(1);
        end else if (head_q == tail_q) begin
          emit.done = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          lst_re    = 1'b1;
          lst_raddr = head_q[VW-1:0];
          head_d    = head_q + CW'(1);
          state_d   = ST_BFS_DQ;
        end
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      visited_q  <= '0;
      row_vld_q  <= '0;
      adj_rvld_q <= 1'b0;
      depth_q    <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      okind_q    <= gdb_pkg::ORDER_DFS;
    end else begin
      state_q   <= state_d;
      visited_q <= visited_d;
      row_vld_q <= row_vld_d;
      if (adj_re) begin
        adj_rvld_q <= row_vld_q[adj_raddr];
      end
      depth_q <= depth_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      okind_q <= okind_d;
    end
  end

  // Edge endpoints of an accepted request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= a_m1[VW-1:0];
      b_q <= b_m1[VW-1:0];
    end
  end

  // Result stage.
  gdb_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (emit),
    .result_valid_o(result_valid_o),
    .vertex_o      (vertex_o),
    .order_kind_o  (order_kind_o),
    .last_o        (last_o)
  );

endmodule

/* hdl/gdb_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gdb_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/gdb_ffs.sv */
// ----------------------------------------------------------------------------
// Find-first unit
// Returns the lowest set bit of a candidate vector, as a two-level search.
// ----------------------------------------------------------------------------
module gdb_ffs (
  input  logic [gdb_pkg::NODE_MAX-1:0] cand_i,
  output gdb_pkg::ffs_res_t            res_o
);

  logic [gdb_pkg::FFS_NGRP-1:0]  grp_any;
  logic [gdb_pkg::FFS_GRP_W-1:0] grp_idx [gdb_pkg::FFS_NGRP];

  // First level: lowest set bit inside each group of eight.
  always_comb begin
    for (int g = 0; g < gdb_pkg::FFS_NGRP; g++) begin
      grp_any[g] = |cand_i[g*gdb_pkg::FFS_GRP +: gdb_pkg::FFS_GRP];
      grp_idx[g] = '0;
      for (int j = gdb_pkg::FFS_GRP - 1; j >= 0; j--) begin
        if (cand_i[g*gdb_pkg::FFS_GRP + j]) begin
          grp_idx[g] = gdb_pkg::FFS_GRP_W'(j);
        end
      end
    end
  end

  // Second level: lowest group that holds a set bit.
  always_comb begin
    logic [gdb_pkg::FFS_NGRP_W-1:0] gsel;
    gsel = '0;
    for (int g = gdb_pkg::FFS_NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        gsel = gdb_pkg::FFS_NGRP_W'(g);
      end
    end
    res_o.found = |grp_any;
    res_o.idx   = {gsel, grp_idx[gsel]};
  end

endmodule

/* hdl/gdb_emit.sv */
// ----------------------------------------------------------------------------
// Result stage
// Holds each visited vertex back by one so that the final one carries last.
// ----------------------------------------------------------------------------
module gdb_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gdb_pkg::emit_req_t            req_i,
  output logic                          result_valid_o,
  output logic [gdb_pkg::FIELD_W-1:0]   vertex_o,
  output logic                          order_kind_o,
  output logic                          last_o
);

  logic                        pend_vld_q, pend_vld_d;
  logic [gdb_pkg::VTX_W-1:0]   pend_vtx_q;
  logic                        pend_kind_q;
  logic                        out_vld_q, out_vld_d;
  logic [gdb_pkg::VTX_W-1:0]   out_vtx_q;
  logic                        out_kind_q;
  logic                        out_last_q, out_last_d;

  // A new vertex pushes the pending one out; the end of a run flushes it as last.
  always_comb begin
    pend_vld_d = pend_vld_q;
    out_vld_d  = 1'b0;
    out_last_d = 1'b0;
    if (req_i.prod) begin
      out_vld_d  = pend_vld_q;
      pend_vld_d = 1'b1;
    end else if (req_i.done) begin
      out_vld_d  = pend_vld_q;
      out_last_d = 1'b1;
      pend_vld_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      out_last_q <= out_last_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (req_i.prod || req_i.done) begin
      out_vtx_q  <= pend_vtx_q;
      out_kind_q <= pend_kind_q;
    end
    if (req_i.prod) begin
      pend_vtx_q  <= req_i.vtx;
      pend_kind_q <= req_i.okind;
    end
  end

  assign result_valid_o = out_vld_q;
  assign vertex_o       = gdb_pkg::FIELD_W'(out_vtx_q) + gdb_pkg::FIELD_W'(1);
  assign order_kind_o   = out_kind_q;
  assign last_o         = out_last_q;

endmodule

/* hdl/gdb_checker.sv */
// ----------------------------------------------------------------------------
// Graph traversal checker
// Port-level properties of the traversal block, bound to its top level.
// ----------------------------------------------------------------------------
module gdb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    kind_i,
  input logic                          result_valid_o,
  input logic [gdb_pkg::FIELD_W-1:0]   vertex_o,
  input logic                          last_o
);

  // Every reported vertex is a real vertex number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (vertex_o != '0) && (vertex_o <= gdb_pkg::FIELD_W'(gdb_pkg::NODE_MAX)))
    else $error("result vertex out of range");

  // An edge or clear request never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && ((kind_i == gdb_pkg::KIND_ADD) || (kind_i == gdb_pkg::KIND_CLR)))
    |=> !result_valid_o)
    else $error("result after an edge or clear request");

  // Nothing follows the final vertex of a run in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o)
    else $error("result right after the last vertex");

  // A vertex that is not the last one is only shown while the run is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy)
    else $error("intermediate vertex while idle");

  // An idle block with no request stays silent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> !result_valid_o)
    else $error("result while idle");

endmodule

bind graph_dfs_bfs_order gdb_checker u_gdb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .kind_i        (kind_i),
  .result_valid_o(result_valid_o),
  .vertex_o      (vertex_o),
  .last_o        (last_o)
);
